@@ rtl/tlrt_pkg.sv @@
`default_nettype none
package tlrt_pkg;

    localparam int LIMIT_MAX   = 32000;
    localparam int CONV_SHIFT  = 9;
    localparam int SCALE_MUL   = 25;
    localparam int SCALE_SHIFT = 5;

    localparam int DIVISOR_W   = 16;
    localparam int DIVIDEND_W  = DIVISOR_W + CONV_SHIFT;
    localparam int STEP_W      = $clog2(DIVIDEND_W + 1);
    localparam int STEPS_CONV  = DIVIDEND_W;
    localparam int STEPS_RAMP  = DIVISOR_W;

    localparam int CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVATE_TIME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEACTIVATE_TIME = 2'd1;

    // previous selection codes
    localparam logic [1:0] SEL_NONE     = 2'd0;
    localparam logic [1:0] SEL_ACTIVE   = 2'd1;
    localparam logic [1:0] SEL_INACTIVE = 2'd2;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;  // left aligned
        logic [DIVISOR_W-1:0]  divisor;
        logic [STEP_W-1:0]     steps;
    } t_div_req;

endpackage
`default_nettype wire

@@ rtl/torque_limit_ramp_transition.sv @@
// Sequence: accept, conversion divide, update, ramp divide, then the S_OUT
// state loads the result register; the ramp divide is skipped when no ramp runs.
// Throughput: one item at a time (o_stall while busy), set by the
// shared bit-serial divider. Result register frees the next accept.
// Reset: synchronous active low; clears config registers and the ramp counter, value and selection memory.
`default_nettype none
module torque_limit_ramp_transition (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [15:0]                     i_wheel_limit_torque,
    input  wire logic [15:0]                     i_conversion_ratio,
    input  wire logic                            i_protect_active,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic signed [15:0]                   o_limited_torque,
    output logic [14:0]                          o_converted_limit,
    output logic                                 o_ramp_running,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [tlrt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [7:0]                      i_cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_DIV1, S_CALC, S_DIV2, S_OUT} t_state;

    t_state r_state;

    logic [7:0]                  r_act_time, r_deact_time;
    logic                        r_active;
    logic [1:0]                  r_prev_sel;
    logic                        r_act_mem;
    logic [7:0]                  r_prev_scaled;
    logic [7:0]                  r_cnt;
    logic                        r_cnt_nz;
    logic signed [15:0]          r_ramp;
    logic [14:0]                 r_conv;
    logic signed [15:0]          r_res;
    logic                        r_neg;

    logic                        r_ovalid;
    logic signed [15:0]          r_lim_out;
    logic [14:0]                 r_conv_out;
    logic                        r_run_out;

    tlrt_pkg::t_div_req          div_req;
    logic [tlrt_pkg::DIVIDEND_W-1:0] div_quo;
    logic                        div_done;

    logic                        accept;
    logic                        out_free;
    logic [14:0]                 conv_cap;
    logic [1:0]                  sel;
    logic [7:0]                  time_sel;
    logic [12:0]                 time_mul;
    logic [7:0]                  scaled;
    logic                        sel_change;
    logic                        n_act_mem;
    logic signed [10:0]          reload_n;
    logic [7:0]                  load;
    logic [7:0]                  n_cnt;
    logic                        n_cnt_nz;
    logic signed [15:0]          target;
    logic signed [16:0]          diff;
    logic [15:0]                 diff_mag;
    logic signed [17:0]          step;
    logic signed [17:0]          ramp_sum;
    logic signed [15:0]          ramp_clamped;

    tlrt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    assign accept      = i_valid && (r_state == S_IDLE);
    assign o_stall     = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_ovalid || !i_stall;

    always_comb begin
        // zero ratio gives an all-ones quotient, which the cap turns into the max
        if (div_quo > tlrt_pkg::DIVIDEND_W'(tlrt_pkg::LIMIT_MAX)) begin
            conv_cap = 15'(tlrt_pkg::LIMIT_MAX);
        end else begin
            conv_cap = div_quo[14:0];
        end

        sel        = r_active ? tlrt_pkg::SEL_ACTIVE : tlrt_pkg::SEL_INACTIVE;
        time_sel   = r_active ? r_act_time : r_deact_time;
        time_mul   = 13'(time_sel) * 13'(tlrt_pkg::SCALE_MUL);
        scaled     = time_mul[tlrt_pkg::SCALE_SHIFT +: 8];
        if (scaled == 8'd0) begin
            scaled = 8'd1;
        end
        sel_change = (sel != r_prev_sel);
        n_act_mem  = sel_change || ((scaled != r_prev_scaled) && r_cnt_nz);

        // retime during a running ramp
        reload_n = $signed({3'b000, scaled}) - $signed({3'b000, r_prev_scaled})
                 + $signed({3'b000, r_cnt}) - 11'sd1;
        if (n_act_mem && !sel_change) begin
            if (reload_n < 0) begin
                load = 8'd0;
            end else if (reload_n > 11'sd255) begin
                load = 8'd255;
            end else begin
                load = reload_n[7:0];
            end
        end else begin
            load = scaled;
        end

        if (n_act_mem && !r_act_mem) begin
            n_cnt = load;
        end else if (r_cnt != 8'd0) begin
            n_cnt = r_cnt - 8'd1;
        end else begin
            n_cnt = r_cnt;
        end
        n_cnt_nz = (n_cnt != 8'd0);

        target   = r_active ? $signed({1'b0, r_conv})
                            : 16'(tlrt_pkg::LIMIT_MAX);
        diff     = 17'(target) - 17'(r_ramp);
        diff_mag = diff[16] ? 16'(-diff) : diff[15:0];

        step     = r_neg ? -$signed({2'b00, div_quo[15:0]})
                         : $signed({2'b00, div_quo[15:0]});
        ramp_sum = 18'(r_ramp) + step;
        if (ramp_sum > 18'(tlrt_pkg::LIMIT_MAX)) begin
            ramp_clamped = 16'(tlrt_pkg::LIMIT_MAX);
        end else if (ramp_sum < -18'(tlrt_pkg::LIMIT_MAX)) begin
            ramp_clamped = -16'(tlrt_pkg::LIMIT_MAX);
        end else begin
            ramp_clamped = ramp_sum[15:0];
        end

        div_req.start    = 1'b0;
        div_req.dividend = {i_wheel_limit_torque, tlrt_pkg::CONV_SHIFT'(0)};
        div_req.divisor  = i_conversion_ratio;
        div_req.steps    = tlrt_pkg::STEP_W'(tlrt_pkg::STEPS_CONV);
        if (accept) begin
            div_req.start = 1'b1;
        end else if (r_state == S_CALC) begin
            div_req.start    = n_cnt_nz;
            div_req.dividend = {diff_mag, tlrt_pkg::CONV_SHIFT'(0)};
            div_req.divisor  = {8'd0, n_cnt};
            div_req.steps    = tlrt_pkg::STEP_W'(tlrt_pkg::STEPS_RAMP);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_act_time    <= '0;
            r_deact_time  <= '0;
            r_prev_sel    <= tlrt_pkg::SEL_NONE;
            r_act_mem     <= 1'b0;
            r_prev_scaled <= '0;
            r_cnt         <= '0;
            r_cnt_nz      <= 1'b0;
            r_ramp        <= '0;
            r_ovalid      <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tlrt_pkg::CFG_ACTIVATE_TIME:   r_act_time   <= i_cfg_data;
                    tlrt_pkg::CFG_DEACTIVATE_TIME: r_deact_time <= i_cfg_data;
                    default: ;
                endcase
            end

            // result beat holds until taken; a new one loads once the slot frees
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_active <= i_protect_active;
                        r_state  <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (div_done) begin
                        r_conv  <= conv_cap;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_prev_sel    <= sel;
                    r_prev_scaled <= scaled;
                    r_act_mem     <= n_act_mem;
                    r_cnt         <= n_cnt;
                    r_cnt_nz      <= n_cnt_nz;
                    r_neg         <= diff[16];
                    r_res         <= n_cnt_nz ? r_ramp : target;
                    r_state       <= n_cnt_nz ? S_DIV2 : S_OUT;
                end
                S_DIV2: begin
                    if (div_done) begin
                        r_ramp  <= ramp_clamped;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_lim_out  <= r_res;
                        r_conv_out <= r_conv;
                        r_run_out  <= r_cnt_nz;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid           = r_ovalid;
    assign o_limited_torque  = r_lim_out;
    assign o_converted_limit = r_conv_out;
    assign o_ramp_running    = r_run_out;

endmodule
`default_nettype wire

@@ rtl/tlrt_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle shifted in at the bottom.
// Dividend is left aligned; after N steps the low N bits hold the quotient.
// Divisor zero yields all ones.
module tlrt_div (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire tlrt_pkg::t_div_req             i_req,
    output logic [tlrt_pkg::DIVIDEND_W-1:0]     o_quo,
    output logic                                o_done
);

    logic [tlrt_pkg::DIVIDEND_W-1:0] r_quo;
    logic [tlrt_pkg::DIVISOR_W-1:0]  r_rem;
    logic [tlrt_pkg::DIVISOR_W-1:0]  r_dvs;
    logic [tlrt_pkg::STEP_W-1:0]     r_cnt;
    logic                            r_busy;
    logic                            r_done;

    logic [tlrt_pkg::DIVISOR_W:0]    rem_sh;
    logic [tlrt_pkg::DIVISOR_W+1:0]  sub;
    logic                            ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[tlrt_pkg::DIVIDEND_W-1]};
        sub    = {1'b0, rem_sh} - {2'b00, r_dvs};
        ge     = !sub[tlrt_pkg::DIVISOR_W+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
                r_quo  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_quo <= {r_quo[tlrt_pkg::DIVIDEND_W-2:0], ge};
                r_rem <= ge ? sub[tlrt_pkg::DIVISOR_W-1:0]
                            : rem_sh[tlrt_pkg::DIVISOR_W-1:0];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == tlrt_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule
`default_nettype wire
